>>> design/dec_pkg.sv
`default_nettype none

package dec_pkg;

  // Outcome reported with every result word.
  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_RESOLVED   = 2'd1,
    ST_COINCIDENT = 2'd2
  } status_e;

  // Divider lanes: the two unit-vector components and the two mass factors.
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_UX   = 0;
  localparam int unsigned LANE_UY   = 1;
  localparam int unsigned LANE_KA   = 2;
  localparam int unsigned LANE_KB   = 3;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic        [31:0] mass_a;
    logic        [30:0] radius_a;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic        [31:0] mass_b;
    logic        [30:0] radius_b;
  } in_t;

  typedef struct packed {
    status_e            contact_status;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
  } out_t;

  // Velocities that ride along with every item.
  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
  } vel_t;

  // Carried alongside the square root.
  typedef struct packed {
    vel_t        vel;
    logic [31:0] adx;
    logic [31:0] ady;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] mass_a;
    logic [31:0] mass_b;
    logic [32:0] msum;
    status_e     status;
  } ctc_side_t;

  // Carried alongside the dividers.
  typedef struct packed {
    vel_t    vel;
    logic    neg_x;
    logic    neg_y;
    logic    msum_zero;
    status_e status;
  } div_side_t;

endpackage

`default_nettype wire

>>> design/dec_stream_if.sv
`default_nettype none

interface dec_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/dec_contact.sv
`default_nettype none

module dec_contact import dec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  in_t       data_i,
  output logic      valid_o,
  output logic [63:0] rad_o,
  output ctc_side_t side_o
);

  // stage 0: center deltas and radius sum
  logic [2:0]         vld_q;
  logic signed [32:0] dx_d, dy_d;
  logic [31:0]        adx_d, ady_d, adx_q, ady_q;
  logic               negx_q, negy_q, coin_q;
  logic [31:0]        rsum_d, rsum_q;
  vel_t               vel0_q, vel1_q;
  logic [31:0]        ma0_q, mb0_q, ma1_q, mb1_q;

  // stage 1: squares
  logic [31:0] adx1_q, ady1_q;
  logic [63:0] sx_q, sy_q, rr_q;
  logic        far_q, coin1_q, negx1_q, negy1_q;
  logic [32:0] msum_q;

  // stage 2: contact decision
  logic [64:0] s_d;
  logic        contact_d;
  status_e     status_d;
  logic [63:0] rad_q;
  ctc_side_t   side_q;

  assign dx_d   = 33'(data_i.pos_b_x) - 33'(data_i.pos_a_x);
  assign dy_d   = 33'(data_i.pos_b_y) - 33'(data_i.pos_a_y);
  assign adx_d  = dx_d[32] ? 32'(-dx_d) : dx_d[31:0];
  assign ady_d  = dy_d[32] ? 32'(-dy_d) : dy_d[31:0];
  assign rsum_d = 32'(data_i.radius_a) + 32'(data_i.radius_b);

  assign s_d       = {1'b0, sx_q} + {1'b0, sy_q};
  assign contact_d = !far_q && (s_d <= {1'b0, rr_q});

  always_comb begin
    if (coin1_q) begin
      status_d = ST_COINCIDENT;
    end else if (contact_d) begin
      status_d = ST_RESOLVED;
    end else begin
      status_d = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      negx_q <= dx_d[32];
      negy_q <= dy_d[32];
      coin_q <= (dx_d == '0) && (dy_d == '0);
      rsum_q <= rsum_d;
      vel0_q <= '{data_i.vel_a_x, data_i.vel_a_y, data_i.vel_b_x, data_i.vel_b_y};
      ma0_q  <= data_i.mass_a;
      mb0_q  <= data_i.mass_b;

      sx_q    <= adx_q * adx_q;
      sy_q    <= ady_q * ady_q;
      rr_q    <= rsum_q * rsum_q;
      far_q   <= (adx_q > rsum_q) || (ady_q > rsum_q);
      coin1_q <= coin_q;
      adx1_q  <= adx_q;
      ady1_q  <= ady_q;
      negx1_q <= negx_q;
      negy1_q <= negy_q;
      msum_q  <= 33'(ma0_q) + 33'(mb0_q);
      vel1_q  <= vel0_q;
      ma1_q   <= ma0_q;
      mb1_q   <= mb0_q;

      rad_q         <= s_d[63:0];
      side_q.vel    <= vel1_q;
      side_q.adx    <= adx1_q;
      side_q.ady    <= ady1_q;
      side_q.neg_x  <= negx1_q;
      side_q.neg_y  <= negy1_q;
      side_q.mass_a <= ma1_q;
      side_q.mass_b <= mb1_q;
      side_q.msum   <= msum_q;
      side_q.status <= status_d;
    end
  end

  assign valid_o = vld_q[2];
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

>>> design/dec_sqrt.sv
`default_nettype none

// Floor square root of a 64-bit radicand, one root bit per stage.
module dec_sqrt #(
  parameter type side_t = logic
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] rad_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output side_t       side_o
);

  localparam int unsigned NS = 32;
  localparam int unsigned RW = 36;

  logic [NS-1:0] vld_q, vld_p;
  logic [RW-1:0] rem_p [NS];
  logic [RW-1:0] rem_q [NS];
  logic [RW-1:0] rem_sh [NS];
  logic [RW-1:0] trial [NS];
  logic [31:0]   root_p [NS];
  logic [31:0]   root_q [NS];
  logic [63:0]   rad_p [NS];
  logic [63:0]   rad_q [NS];
  side_t         side_p [NS];
  side_t         side_q [NS];
  logic [NS-1:0] ge;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign vld_p[k]  = valid_i;
      assign rem_p[k]  = '0;
      assign root_p[k] = '0;
      assign rad_p[k]  = rad_i;
      assign side_p[k] = side_i;
    end else begin : g_body
      assign vld_p[k]  = vld_q[k-1];
      assign rem_p[k]  = rem_q[k-1];
      assign root_p[k] = root_q[k-1];
      assign rad_p[k]  = rad_q[k-1];
      assign side_p[k] = side_q[k-1];
    end

    assign rem_sh[k] = {rem_p[k][RW-3:0], rad_p[k][63:62]};
    assign trial[k]  = RW'({root_p[k], 2'b01});
    assign ge[k]     = rem_sh[k] >= trial[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
        root_q[k] <= {root_p[k][30:0], ge[k]};
        rad_q[k]  <= {rad_p[k][61:0], 2'b00};
        side_q[k] <= side_p[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

>>> design/dec_div.sv
`default_nettype none

// floor(num * 2^QB / den) for num <= den, one quotient bit per stage, on parallel lanes.
module dec_div #(
  parameter int unsigned QB    = 17,
  parameter int unsigned LANES = 4,
  parameter type side_t = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   num_i [LANES],
  input  logic [32:0]   den_i [LANES],
  input  side_t         side_i,
  output logic          valid_o,
  output logic [QB:0]   quo_o [LANES],
  output side_t         side_o
);

  localparam int unsigned NS = QB + 1;

  logic [NS-1:0] vld_q, vld_p;
  side_t         side_p [NS];
  side_t         side_q [NS];

  logic [32:0] rem_q [NS][LANES];
  logic [32:0] rem_p [NS][LANES];
  logic [33:0] rem_sh [NS][LANES];
  logic [32:0] den_q [NS][LANES];
  logic [32:0] den_p [NS][LANES];
  logic [QB:0] quo_q [NS][LANES];
  logic [QB:0] quo_p [NS][LANES];
  logic        ge [NS][LANES];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_head
      assign vld_p[k]  = valid_i;
      assign side_p[k] = side_i;
    end else begin : g_body
      assign vld_p[k]  = vld_q[k-1];
      assign side_p[k] = side_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (k == 0) begin : g_head
        // top quotient bit: no doubling yet
        assign rem_p[k][l]  = 33'(num_i[l]);
        assign den_p[k][l]  = den_i[l];
        assign quo_p[k][l]  = '0;
        assign rem_sh[k][l] = {1'b0, rem_p[k][l]};
      end else begin : g_body
        assign rem_p[k][l]  = rem_q[k-1][l];
        assign den_p[k][l]  = den_q[k-1][l];
        assign quo_p[k][l]  = quo_q[k-1][l];
        assign rem_sh[k][l] = {rem_p[k][l], 1'b0};
      end

      assign ge[k][l] = rem_sh[k][l] >= {1'b0, den_p[k][l]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge[k][l] ? 33'(rem_sh[k][l] - {1'b0, den_p[k][l]})
                                  : 33'(rem_sh[k][l]);
          den_q[k][l] <= den_p[k][l];
          quo_q[k][l] <= {quo_p[k][l][QB-1:0], ge[k][l]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_p[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = quo_q[NS-1][l];
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

>>> design/dec_resolve.sv
`default_nettype none

// Normal/tangential split, 1D exchange and rotation back, seven register stages.
module dec_resolve import dec_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [FRAC_BITS+1:0]  quo_i [NUM_LANES],
  input  div_side_t             side_i,
  output logic                  valid_o,
  output out_t                  data_o
);

  localparam int unsigned UW = FRAC_BITS + 2;
  localparam int unsigned PW = UW + 32;
  localparam int unsigned KW = UW + 34;
  localparam int unsigned WW = FRAC_BITS + 40;
  localparam int unsigned NS = 7;

  function automatic logic signed [WW-1:0] trunc_f(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] bias;
    bias = x[WW-1] ? $signed(WW'((64'd1 << FRAC_BITS) - 64'd1)) : '0;
    return (x + bias) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat_f(input logic signed [WW-1:0] x);
    logic signed [31:0] r;
    if ((&x[WW-1:31]) || !(|x[WW-1:31])) begin
      r = x[31:0];
    end else if (x[WW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  logic [NS-1:0] vld_q;
  vel_t          vel_q [NS];
  status_e       st_q [NS];

  // R0
  logic [UW-1:0]        mag_x, mag_y;
  logic signed [UW-1:0] ux0_q, uy0_q;
  logic [UW-1:0]        ka_q, kb_q;
  // R1
  logic signed [UW-1:0] ux1_q, uy1_q;
  logic [UW-1:0]        ka1_q, kb1_q;
  logic signed [PW-1:0] anx_q, any_q, atx_q, aty_q, bnx_q, bny_q, btx_q, bty_q;
  // R2
  logic signed [UW-1:0] ux2_q, uy2_q;
  logic [UW-1:0]        ka2_q, kb2_q;
  logic signed [31:0]   van_q, vat_q, vbn_q, vbt_q;
  // R3
  logic signed [UW-1:0] ux3_q, uy3_q;
  logic signed [31:0]   van3_q, vat3_q, vbn3_q, vbt3_q;
  logic signed [32:0]   dab, dba;
  logic signed [KW-1:0] pa_q, pb_q;
  // R4
  logic signed [UW-1:0] ux4_q, uy4_q;
  logic signed [31:0]   nan_q, nbn_q, vat4_q, vbt4_q;
  // R5
  logic signed [PW-1:0] m1a_q, m2a_q, m3a_q, m4a_q, m1b_q, m2b_q, m3b_q, m4b_q;
  // R6
  out_t                 out_q;

  assign mag_x = {1'b0, quo_i[LANE_UX][UW-1:1]};
  assign mag_y = {1'b0, quo_i[LANE_UY][UW-1:1]};
  assign dab   = 33'(vbn_q) - 33'(van_q);
  assign dba   = 33'(van_q) - 33'(vbn_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vel_q[0] <= side_i.vel;
      st_q[0]  <= side_i.status;
      for (int k = 1; k < NS; k++) begin
        vel_q[k] <= vel_q[k-1];
        st_q[k]  <= st_q[k-1];
      end

      // R0: signed unit vector and mass factors
      ux0_q <= side_i.neg_x ? -$signed(mag_x) : $signed(mag_x);
      uy0_q <= side_i.neg_y ? -$signed(mag_y) : $signed(mag_y);
      ka_q  <= side_i.msum_zero ? UW'(1) << FRAC_BITS : quo_i[LANE_KA];
      kb_q  <= side_i.msum_zero ? UW'(1) << FRAC_BITS : quo_i[LANE_KB];

      // R1: projection products
      anx_q <= ux0_q * vel_q[0].vel_a_x;
      any_q <= uy0_q * vel_q[0].vel_a_y;
      atx_q <= ux0_q * vel_q[0].vel_a_y;
      aty_q <= uy0_q * vel_q[0].vel_a_x;
      bnx_q <= ux0_q * vel_q[0].vel_b_x;
      bny_q <= uy0_q * vel_q[0].vel_b_y;
      btx_q <= ux0_q * vel_q[0].vel_b_y;
      bty_q <= uy0_q * vel_q[0].vel_b_x;
      ux1_q <= ux0_q;
      uy1_q <= uy0_q;
      ka1_q <= ka_q;
      kb1_q <= kb_q;

      // R2: normal and tangential components
      van_q <= sat_f(trunc_f(WW'(anx_q) + WW'(any_q)));
      vat_q <= sat_f(trunc_f(WW'(atx_q) - WW'(aty_q)));
      vbn_q <= sat_f(trunc_f(WW'(bnx_q) + WW'(bny_q)));
      vbt_q <= sat_f(trunc_f(WW'(btx_q) - WW'(bty_q)));
      ux2_q <= ux1_q;
      uy2_q <= uy1_q;
      ka2_q <= ka1_q;
      kb2_q <= kb1_q;

      // R3: mass-weighted exchange products
      pa_q   <= $signed({1'b0, ka2_q}) * dab;
      pb_q   <= $signed({1'b0, kb2_q}) * dba;
      van3_q <= van_q;
      vat3_q <= vat_q;
      vbn3_q <= vbn_q;
      vbt3_q <= vbt_q;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;

      // R4: new normal components
      nan_q  <= sat_f(WW'(van3_q) + trunc_f(WW'(pa_q)));
      nbn_q  <= sat_f(WW'(vbn3_q) + trunc_f(WW'(pb_q)));
      vat4_q <= vat3_q;
      vbt4_q <= vbt3_q;
      ux4_q  <= ux3_q;
      uy4_q  <= uy3_q;

      // R5: rotate back, products
      m1a_q <= nan_q * ux4_q;
      m2a_q <= vat4_q * uy4_q;
      m3a_q <= nan_q * uy4_q;
      m4a_q <= vat4_q * ux4_q;
      m1b_q <= nbn_q * ux4_q;
      m2b_q <= vbt4_q * uy4_q;
      m3b_q <= nbn_q * uy4_q;
      m4b_q <= vbt4_q * ux4_q;

      // R6: final sums, pass velocities through unless resolved
      out_q.contact_status <= st_q[5];
      if (st_q[5] == ST_RESOLVED) begin
        out_q.new_vel_a_x <= sat_f(trunc_f(WW'(m1a_q) - WW'(m2a_q)));
        out_q.new_vel_a_y <= sat_f(trunc_f(WW'(m3a_q) + WW'(m4a_q)));
        out_q.new_vel_b_x <= sat_f(trunc_f(WW'(m1b_q) - WW'(m2b_q)));
        out_q.new_vel_b_y <= sat_f(trunc_f(WW'(m3b_q) + WW'(m4b_q)));
      end else begin
        out_q.new_vel_a_x <= vel_q[5].vel_a_x;
        out_q.new_vel_a_y <= vel_q[5].vel_a_y;
        out_q.new_vel_b_x <= vel_q[5].vel_b_x;
        out_q.new_vel_b_y <= vel_q[5].vel_b_y;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign data_o  = out_q;

endmodule

`default_nettype wire

>>> design/disc_elastic_collision_top.sv
// Two-disc elastic collision resolver.
// in_i carries one word per disc pair: centers, velocities, masses and radii of
// discs A and B in fixed point with FRAC_BITS fraction bits (centers and velocities
// signed, masses and radii unsigned). out_o returns one word per input word, in
// order: contact_status (none, resolved, coincident centers) and both velocities
// after the step. Discs that do not touch, or whose centers coincide, leave with
// their velocities unchanged. Words pass through the contact test, the
// one-bit-per-stage square root, the parallel one-bit-per-stage divider lanes
// (unit vector and mass factors) and the multiply/saturate stages that rotate,
// exchange and rotate back. Throughput is one word per cycle while the receiver
// accepts results; the whole pipeline advances together.
// When the receiver holds ready low with a result waiting, every stage holds,
// in_i.ready drops in the same cycle, and nothing is lost or repeated; bubbles
// in the pipeline still advance while the output stage is empty.
// Reset clears the valid bits of all stages; the data registers are not reset.
`default_nettype none

module disc_elastic_collision_top import dec_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dec_stream_if.sink     in_i,
  dec_stream_if.source   out_o
);

  localparam int unsigned QB = FRAC_BITS + 1;

  logic        adv;
  logic        ctc_valid, sq_valid, div_valid, res_valid;
  logic [63:0] ctc_rad;
  ctc_side_t   ctc_side, sq_side;
  logic [31:0] sq_root;
  logic [31:0] num [NUM_LANES];
  logic [32:0] den [NUM_LANES];
  div_side_t   div_side_in, div_side;
  logic [QB:0] quo [NUM_LANES];
  out_t        res_data;

  // Advance whenever the output stage is empty or being drained.
  assign adv        = !res_valid || out_o.ready;
  assign in_i.ready = adv;

  dec_contact u_contact (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (ctc_valid),
    .rad_o   (ctc_rad),
    .side_o  (ctc_side)
  );

  dec_sqrt #(
    .side_t (ctc_side_t)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ctc_valid),
    .rad_i   (ctc_rad),
    .side_i  (ctc_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Unit vector is |d| / len; mass factors are m / (ma + mb), all scaled by 2^QB.
  assign num[LANE_UX] = sq_side.adx;
  assign den[LANE_UX] = {1'b0, sq_root};
  assign num[LANE_UY] = sq_side.ady;
  assign den[LANE_UY] = {1'b0, sq_root};
  assign num[LANE_KA] = sq_side.mass_b;
  assign den[LANE_KA] = sq_side.msum;
  assign num[LANE_KB] = sq_side.mass_a;
  assign den[LANE_KB] = sq_side.msum;

  assign div_side_in.vel       = sq_side.vel;
  assign div_side_in.neg_x     = sq_side.neg_x;
  assign div_side_in.neg_y     = sq_side.neg_y;
  assign div_side_in.msum_zero = (sq_side.msum == '0);
  assign div_side_in.status    = sq_side.status;

  dec_div #(
    .QB     (QB),
    .LANES  (NUM_LANES),
    .side_t (div_side_t)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .num_i   (num),
    .den_i   (den),
    .side_i  (div_side_in),
    .valid_o (div_valid),
    .quo_o   (quo),
    .side_o  (div_side)
  );

  dec_resolve #(
    .FRAC_BITS (FRAC_BITS)
  ) u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_valid),
    .quo_i   (quo),
    .side_i  (div_side),
    .valid_o (res_valid),
    .data_o  (res_data)
  );

  assign out_o.valid = res_valid;
  assign out_o.data  = res_data;

endmodule

`default_nettype wire

>>> tb/dec_stream_if.sv
`timescale 1ns / 100ps

>>> tb/disc_elastic_collision_top_tb.sv
`timescale 1ns / 100ps

module disc_elastic_collision_top_tb;
  import dec_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic clk_i;
  logic rst_ni;
  dec_stream_if #(.data_t(in_t))  pair_if ();
  dec_stream_if #(.data_t(out_t)) vel_if ();

  disc_elastic_collision_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (vel_if)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  out_t expected_vel_q[$];
  int   error_cnt;
  bit   steady;  // when set, neither side inserts idle cycles

  // ---------------------------------------------------------------------------
  // Predictor: clamp, truncate-toward-zero shift, integer square root and the
  // full rotate / exchange / rotate-back sequence on the disc pair.
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  function automatic longint drop_frac(longint x);
    return x / ONE;  // signed division truncates toward zero
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic out_t resolve_pair(in_t w);
    out_t            o;
    longint          dx, dy, len, ux, uy;
    longint          vax, vay, vbx, vby;
    longint          van, vat, vbn, vbt, ka, kb, nva, nvb;
    longint unsigned adx, ady, rsum, ma, mb, msum;
    logic [65:0]     dist_sq, reach_sq;
    vax = w.vel_a_x;
    vay = w.vel_a_y;
    vbx = w.vel_b_x;
    vby = w.vel_b_y;
    o.contact_status = ST_NONE;
    o.new_vel_a_x = w.vel_a_x;
    o.new_vel_a_y = w.vel_a_y;
    o.new_vel_b_x = w.vel_b_x;
    o.new_vel_b_y = w.vel_b_y;
    dx = longint'(w.pos_b_x) - longint'(w.pos_a_x);
    dy = longint'(w.pos_b_y) - longint'(w.pos_a_y);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    rsum = longint'(w.radius_a) + longint'(w.radius_b);
    if (adx == 0 && ady == 0) begin
      o.contact_status = ST_COINCIDENT;
      return o;
    end
    // Exact contact test, wide enough that nothing wraps.
    dist_sq  = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
    reach_sq = 66'(rsum) * 66'(rsum);
    if (dist_sq > reach_sq) return o;
    len = longint'(root_floor(dist_sq[63:0]));
    ux = dx * ONE / len;
    uy = dy * ONE / len;
    van = clamp32(drop_frac(ux * vax + uy * vay));
    vat = clamp32(drop_frac(ux * vay - uy * vax));
    vbn = clamp32(drop_frac(ux * vbx + uy * vby));
    vbt = clamp32(drop_frac(ux * vby - uy * vbx));
    ma = w.mass_a;
    mb = w.mass_b;
    msum = ma + mb;
    if (msum == 0) begin
      ka = ONE;
      kb = ONE;
    end else begin
      ka = longint'(((2 * mb) << FRAC) / msum);
      kb = longint'(((2 * ma) << FRAC) / msum);
    end
    nva = clamp32(van + drop_frac(ka * (vbn - van)));
    nvb = clamp32(vbn + drop_frac(kb * (van - vbn)));
    o.contact_status = ST_RESOLVED;
    o.new_vel_a_x = 32'(clamp32(drop_frac(nva * ux - vat * uy)));
    o.new_vel_a_y = 32'(clamp32(drop_frac(nva * uy + vat * ux)));
    o.new_vel_b_x = 32'(clamp32(drop_frac(nvb * ux - vbt * uy)));
    o.new_vel_b_y = 32'(clamp32(drop_frac(nvb * uy + vbt * ux)));
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the word until it is accepted. Valid
  // stays high between back-to-back words so it never toggles within one step.
  // ---------------------------------------------------------------------------
  task automatic send_pair(in_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      pair_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.data  <= w;
    do @(posedge clk_i); while (!pair_if.ready);
    expected_vel_q.push_back(resolve_pair(w));
  endtask

  // Receiver: draw a stall per result word, then hold ready until it moves.
  initial begin
    int gap;
    vel_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        vel_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      vel_if.ready <= 1'b1;
      do @(posedge clk_i); while (!vel_if.valid);
    end
  end

  // Checker: compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && vel_if.valid && vel_if.ready) begin
      if (expected_vel_q.size() == 0) begin
        $error("result word with nothing expected");
        error_cnt++;
      end else begin
        out_t e;
        out_t a;
        e = expected_vel_q.pop_front();
        a = vel_if.data;
        if (a.contact_status !== e.contact_status) begin
          $error("contact_status: expected %0d, got %0d", e.contact_status, a.contact_status);
          error_cnt++;
        end
        if (a.new_vel_a_x !== e.new_vel_a_x) begin
          $error("new_vel_a_x: expected %0d, got %0d", e.new_vel_a_x, a.new_vel_a_x);
          error_cnt++;
        end
        if (a.new_vel_a_y !== e.new_vel_a_y) begin
          $error("new_vel_a_y: expected %0d, got %0d", e.new_vel_a_y, a.new_vel_a_y);
          error_cnt++;
        end
        if (a.new_vel_b_x !== e.new_vel_b_x) begin
          $error("new_vel_b_x: expected %0d, got %0d", e.new_vel_b_x, a.new_vel_b_x);
          error_cnt++;
        end
        if (a.new_vel_b_y !== e.new_vel_b_y) begin
          $error("new_vel_b_y: expected %0d, got %0d", e.new_vel_b_y, a.new_vel_b_y);
          error_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  // Random value at a random magnitude so small, medium and huge all show up.
  function automatic logic [31:0] any_scale();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] any_signed();
    logic [31:0] v;
    v = any_scale();
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] any_mass();
    logic [31:0] m;
    m = any_scale();
    return (m == 0) ? 32'd1 : m;
  endfunction

  function automatic in_t disc_pair(longint pax, longint pay, longint dx, longint dy,
                                    longint ra, longint rb);
    in_t w;
    w.pos_a_x  = 32'(pax);
    w.pos_a_y  = 32'(pay);
    w.pos_b_x  = 32'(pax + dx);
    w.pos_b_y  = 32'(pay + dy);
    w.radius_a = 31'(ra);
    w.radius_b = 31'(rb);
    w.vel_a_x  = any_signed();
    w.vel_a_y  = any_signed();
    w.vel_b_x  = any_signed();
    w.vel_b_y  = any_signed();
    w.mass_a   = any_mass();
    w.mass_b   = any_mass();
    return w;
  endfunction

  // A pair whose centers lie within (or near) reach: most of them collide.
  function automatic in_t touching_pair();
    longint ra, rb, reach, dx, dy;
    ra = $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30);
    rb = $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 30);
    reach = ra + rb;
    if (reach > 32'hffffffff) reach = 32'hffffffff;
    dx = longint'($urandom()) % (reach + 1);
    dy = longint'($urandom()) % (reach * 3 / 4 + 1);
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    if ($urandom_range(0, 15) == 0) dy = 0;
    if ($urandom_range(0, 31) == 0) begin
      dx = 0;
      dy = 0;
    end
    return disc_pair(longint'(signed'(any_signed())), longint'(signed'(any_signed())),
                     dx, dy, ra, rb);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    in_t w;
    // apart, no contact
    send_pair(disc_pair(0, 0, 5 * ONE, 0, ONE, ONE));
    // touching exactly along x, and along a 3-4-5 diagonal
    send_pair(disc_pair(0, 0, 2 * ONE, 0, ONE, ONE));
    send_pair(disc_pair(ONE, -ONE, 3 * ONE, 4 * ONE, 2 * ONE, 3 * ONE));
    // one lsb beyond touching
    send_pair(disc_pair(0, 0, 2 * ONE + 1, 0, ONE, ONE));
    // coincident centers, with and without radii
    send_pair(disc_pair(7 * ONE, -3 * ONE, 0, 0, ONE, ONE));
    send_pair(disc_pair(0, 0, 0, 0, 0, 0));
    // zero radii one lsb apart
    send_pair(disc_pair(0, 0, 1, 1, 0, 0));
    // huge distances: opposite corners of the plane, maximum radii
    send_pair(disc_pair(S32_MIN, S32_MIN, 64'hffffffff, 64'hffffffff,
                        31'h7fffffff, 31'h7fffffff));
    send_pair(disc_pair(S32_MIN, 0, 64'hffffffff, 0, 31'h7fffffff, 31'h7fffffff));
    send_pair(disc_pair(S32_MAX, S32_MAX, -64'hffffffff, 0, 31'h7fffffff, 0));
    // head-on, equal masses: velocities swap
    w = disc_pair(0, 0, ONE, 0, ONE, ONE);
    w.vel_a_x = 32'(ONE);  w.vel_a_y = 0;  w.vel_b_x = 32'(-ONE);  w.vel_b_y = 0;
    w.mass_a = 32'(ONE);   w.mass_b = 32'(ONE);
    send_pair(w);
    // extreme masses and extreme velocities, to drive saturation
    w = disc_pair(0, 0, ONE, ONE, ONE, ONE);
    w.mass_a = 32'd1;  w.mass_b = 32'hffffffff;
    w.vel_a_x = 32'h7fffffff;  w.vel_a_y = 32'h80000000;
    w.vel_b_x = 32'h80000000;  w.vel_b_y = 32'h7fffffff;
    send_pair(w);
    w.mass_a = 32'hffffffff;  w.mass_b = 32'd1;
    send_pair(w);
    w.mass_a = 32'hffffffff;  w.mass_b = 32'hffffffff;
    w.vel_a_y = 32'h7fffffff;  w.vel_b_x = 32'h7fffffff;
    send_pair(w);
    w = disc_pair(-5, 9, -3, 2, 1, 3);
    w.vel_a_x = 32'h80000000;  w.vel_a_y = 32'h80000000;
    w.vel_b_x = 32'h7fffffff;  w.vel_b_y = 32'h7fffffff;
    w.mass_a = 32'd1;  w.mass_b = 32'd1;
    send_pair(w);
  endtask

  // Mostly contact pairs with random content; steady and gappy stretches.
  task automatic test_contact_sweep(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      send_pair(touching_pair());
    end
    steady = 1'b0;
  endtask

  // Fully random words: every bit of every field toggles.
  task automatic test_noise(int count);
    in_t          w;
    logic [383:0] raw;
    for (int i = 0; i < count; i++) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      w = raw[$bits(in_t)-1:0];
      if (w.mass_a == 0) w.mass_a = 32'd1;
      if (w.mass_b == 0) w.mass_b = 32'd1;
      send_pair(w);
    end
  endtask

  // Let the pipeline run dry before sending more.
  task automatic test_drain_pause(int count);
    test_contact_sweep(count);
    pair_if.valid <= 1'b0;
    while (expected_vel_q.size() != 0) @(posedge clk_i);
    test_contact_sweep(count);
  endtask

  initial begin
    error_cnt = 0;
    steady = 1'b0;
    rst_ni = 1'b0;
    pair_if.valid <= 1'b0;
    pair_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_contact_sweep(1200);
    test_noise(300);
    test_drain_pause(160);

    pair_if.valid <= 1'b0;
    while (expected_vel_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
